// ----- rtl/core/ptt_pkg.sv -----
package ptt_pkg;

	localparam int RECORD_COUNT = 16;
	localparam int PROFILE_COUNT = 8;
	localparam int LOCATION_COUNT = 64;
	localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
	localparam int CNT_W = $clog2(RECORD_COUNT + 1);
	localparam logic [7:0] PROFILE_IGNORE = 8'hFF;

	localparam logic [1:0] CMD_REPORT = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_THROTTLE = 2'd1;
	localparam logic [1:0] REG_SPREAD = 2'd2;

	localparam logic [3:0] KIND_MESH = 4'd0;
	localparam logic [3:0] KIND_LOC_ENTER = 4'd1;
	localparam logic [3:0] KIND_LOC_EXIT = 4'd2;
	localparam logic [3:0] KIND_FIRST_ENTER = 4'd3;
	localparam logic [3:0] KIND_LAST_EXIT = 4'd4;
	localparam logic [3:0] KIND_PROF_ENTER = 4'd5;
	localparam logic [3:0] KIND_PROF_EXIT = 4'd6;
	localparam logic [3:0] KIND_MUTATION = 4'd7;
	localparam logic [3:0] KIND_QUERY = 4'd8;

	localparam logic [2:0] MUT_NONE = 3'd0;
	localparam logic [2:0] MUT_FIRST = 3'd1;
	localparam logic [2:0] MUT_LAST = 3'd2;
	localparam logic [2:0] MUT_CHANGED = 3'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] profile;
		logic [7:0] location;
		logic       forward_to_mesh;
		logic [7:0] random_byte;
		logic       presence_certain;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  profile_out;
		logic [5:0]  location_out;
		logic [2:0]  mutation;
		logic [63:0] occupied_mask;
		logic        last;
	} out_item_t;

	// stored record: profile(3) location(6) timeout(16) mesh(9)
	typedef struct packed {
		logic [2:0]  prof;
		logic [5:0]  loc;
		logic [15:0] tmo;
		logic [8:0]  mesh;
	} record_t;

	localparam int REC_W = $bits(record_t);

	// event without mask and last flag
	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] prof;
		logic [5:0] loc;
		logic [2:0] mut;
	} event_t;

endpackage

// ----- rtl/core/ptt_ram.sv -----
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/ptt_mod.sv -----
// remainder of a byte by a byte, one quotient bit per cycle
module ptt_mod
	import ptt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [7:0] divisor,
	output logic       done,
	output logic [7:0] remainder
);

	logic [7:0] rem_q;
	logic [7:0] num_q;
	logic [7:0] den_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic [8:0] trial;

	assign trial = {rem_q, num_q[7]} - {1'b0, den_q};
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd8;
				rem_q <= '0;
				num_q <= dividend;
				den_q <= divisor;
			end else if (busy_q) begin
				if (!trial[8]) begin
					rem_q <= trial[7:0];
				end else begin
					rem_q <= {rem_q[6:0], num_q[7]};
				end
				num_q <= {num_q[6:0], 1'b0};
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/ptt_evq.sv -----
// event queue: holds the events of one item until the mask is known
module ptt_evq
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  event_t      push_ev,
	input  logic        clear,
	input  logic        drain,
	input  logic [63:0] mask,
	output logic        empty,
	output logic        valid,
	input  logic        stall,
	output out_item_t   out
);

	localparam int QD = 32;
	localparam int QW = $clog2(QD);

	logic [QW:0]   wr_q;
	logic [QW:0]   rd_q;
	logic          rd_pend_q;
	logic          busy_q;
	logic [$bits(event_t)-1:0] rdata;
	logic          take;
	logic          fetch;
	logic          have_q;

	ptt_ram #(.WIDTH($bits(event_t)), .DEPTH(QD)) u_ram (
		.clk(clk),
		.we(push),
		.waddr(wr_q[QW-1:0]),
		.wdata(push_ev),
		.raddr(rd_q[QW-1:0]),
		.rdata(rdata)
	);

	assign take = valid && !stall;
	assign fetch = busy_q && !rd_pend_q && (rd_q != wr_q) && (!have_q || take);
	assign empty = !busy_q && !have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			rd_pend_q <= 1'b0;
			busy_q <= 1'b0;
			have_q <= 1'b0;
			valid <= 1'b0;
		end else begin
			if (clear) begin
				wr_q <= '0;
				rd_q <= '0;
			end else if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (drain) begin
				busy_q <= 1'b1;
			end
			if (take) begin
				have_q <= 1'b0;
				valid <= 1'b0;
			end
			rd_pend_q <= 1'b0;
			if (fetch) begin
				rd_q <= rd_q + 1'b1;
				rd_pend_q <= 1'b1;
			end
			if (rd_pend_q) begin
				have_q <= 1'b1;
				valid <= 1'b1;
				out.kind <= rdata[15:12];
				out.profile_out <= rdata[11:9];
				out.location_out <= rdata[8:3];
				out.mutation <= rdata[2:0];
				out.occupied_mask <= mask;
				out.last <= (rd_q == wr_q);
				if (rd_q == wr_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/core/ptt_ctrl.sv -----
// sequencer: scans the record memory, modifies records, queues events
module ptt_ctrl
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        q_empty,
	output logic        q_push,
	output event_t      q_ev,
	output logic        q_clear,
	output logic        q_drain,
	output logic [63:0] mask
);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN, S_DIV, S_RD, S_WR, S_TICK, S_TAIL, S_WAIT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [15:0] tmo_q;
	logic [7:0]  thr_q;
	logic [7:0]  spr_q;
	logic [IDX_W:0] idx_q;
	logic [IDX_W-1:0] sel_q;
	logic match_q;
	logic free_q;
	logic [15:0] min_q;
	logic [63:0] prev_q;
	logic [63:0] acc_q;
	logic        rd_pend_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [2:0] tail_q;
	logic [2:0] mut_q;
	logic [8:0] cd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W:0] init_q;

	logic        we;
	logic [IDX_W-1:0] waddr;
	record_t     wdata;
	logic [IDX_W-1:0] raddr;
	record_t     rdata;
	logic        div_start;
	logic        div_done;
	logic [7:0]  div_rem;
	logic [63:0] next_mask;
	logic [63:0] rep_mask;

	ptt_ram #(.WIDTH(REC_W), .DEPTH(RECORD_COUNT)) u_rec (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	ptt_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(item_q.random_byte), .divisor(spr_q),
		.done(div_done), .remainder(div_rem)
	);

	assign in_stall = (state_q != S_IDLE);
	assign raddr = idx_q[IDX_W-1:0];

	function automatic logic [2:0] mut_code(logic c, logic [63:0] p, logic [63:0] n);
		logic [2:0] r;
		if (!c || p == n) r = MUT_NONE;
		else if (p == 64'd0) r = MUT_FIRST;
		else if (n == 64'd0) r = MUT_LAST;
		else r = MUT_CHANGED;
		return r;
	endfunction

	// mask after the report: recount with the selected slot replaced
	assign next_mask = acc_q;
	assign rep_mask = item_q.presence_certain ? next_mask : 64'd0;

	always_comb begin
		we = 1'b0;
		waddr = sel_q;
		wdata = '0;
		// kick the remainder unit on the way into the wait state
		div_start = (state_q == S_DIV) && (cd_q == 9'd0) && (spr_q != 8'd0);
		if (state_q == S_INIT) begin
			we = 1'b1;
			waddr = init_q[IDX_W-1:0];
		end
		if (state_q == S_WR) begin
			we = 1'b1;
			wdata.prof = item_q.profile[2:0];
			wdata.loc = item_q.location[5:0];
			wdata.tmo = tmo_q;
			wdata.mesh = cd_q;
		end
		if (state_q == S_TICK && item_q.command == CMD_TICK && rd_pend_q &&
		    rdata.tmo != 16'd0) begin
			we = 1'b1;
			waddr = rd_idx_q;
			wdata = rdata;
			wdata.tmo = rdata.tmo - 16'd1;
			if (rdata.tmo != 16'd1 && rdata.mesh != 9'd0) begin
				wdata.mesh = rdata.mesh - 9'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			tmo_q <= 16'd60;
			thr_q <= 8'd30;
			spr_q <= 8'd30;
			q_push <= 1'b0;
			q_clear <= 1'b0;
			q_drain <= 1'b0;
			mask <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			q_push <= 1'b0;
			q_clear <= 1'b0;
			q_drain <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIMEOUT:  tmo_q <= cfg_data;
					REG_THROTTLE: thr_q <= cfg_data[7:0];
					REG_SPREAD:   spr_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (IDX_W+1)'(RECORD_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						match_q <= 1'b0;
						free_q <= 1'b0;
						min_q <= 16'hFFFF;
						sel_q <= '0;
						prev_q <= '0;
						acc_q <= '0;
						cnt_q <= '0;
						q_clear <= 1'b1;
						if (in_data.command == CMD_REPORT &&
						    in_data.profile < 8'(PROFILE_COUNT) &&
						    in_data.location < 8'(LOCATION_COUNT)) begin
							state_q <= S_SCAN;
						end else if (in_data.command == CMD_TICK) begin
							state_q <= S_TICK;
						end else if (in_data.command == CMD_QUERY) begin
							state_q <= S_TICK;
						end
					end
				end
				S_SCAN: begin
					// stream reads; evaluate the previous read
					rd_pend_q <= (idx_q < (IDX_W+1)'(RECORD_COUNT));
					rd_idx_q <= idx_q[IDX_W-1:0];
					if (idx_q < (IDX_W+1)'(RECORD_COUNT)) idx_q <= idx_q + 1'b1;
					if (rd_pend_q) begin
						if (rdata.tmo != 16'd0) begin
							prev_q <= prev_q | (64'd1 << rdata.loc);
							if (!match_q && rdata.prof == item_q.profile[2:0] &&
							    rdata.loc == item_q.location[5:0]) begin
								match_q <= 1'b1;
								sel_q <= rd_idx_q;
								cd_q <= rdata.mesh;
							end else if (!match_q && !free_q &&
							    (rd_idx_q == '0 || rdata.tmo < min_q)) begin
								min_q <= rdata.tmo;
								sel_q <= rd_idx_q;
							end
						end else if (!free_q) begin
							free_q <= 1'b1;
							if (!match_q) sel_q <= rd_idx_q;
						end
					end else if (idx_q == (IDX_W+1)'(RECORD_COUNT)) begin
						if (!match_q) cd_q <= 9'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cd_q == 9'd0 && item_q.forward_to_mesh) begin
						q_push <= 1'b1;
						q_ev <= '{KIND_MESH, item_q.profile[2:0], item_q.location[5:0],
						          MUT_NONE};
						cnt_q <= cnt_q + 1'b1;
					end
					if (cd_q != 9'd0 || spr_q == 8'd0) begin
						if (cd_q == 9'd0) cd_q <= {1'b0, thr_q};
						state_q <= S_WR;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// started on entry; wait for the remainder
					if (div_done) begin
						cd_q <= {1'b0, thr_q} + {1'b0, div_rem};
						state_q <= S_WR;
					end
				end
				S_WR: begin
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					acc_q <= '0;
					state_q <= S_TAIL;
					tail_q <= '0;
					if (!match_q) begin
						q_push <= 1'b1;
						q_ev <= '{KIND_LOC_ENTER, item_q.profile[2:0],
						          item_q.location[5:0], MUT_NONE};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TICK: begin
					rd_pend_q <= (idx_q < (IDX_W+1)'(RECORD_COUNT));
					rd_idx_q <= idx_q[IDX_W-1:0];
					if (idx_q < (IDX_W+1)'(RECORD_COUNT)) idx_q <= idx_q + 1'b1;
					if (rd_pend_q && rdata.tmo != 16'd0) begin
						if (item_q.command == CMD_TICK) begin
							prev_q <= prev_q | (64'd1 << rdata.loc);
							if (rdata.tmo == 16'd1) begin
								q_push <= 1'b1;
								q_ev <= '{KIND_LOC_EXIT, rdata.prof, rdata.loc, MUT_NONE};
								cnt_q <= cnt_q + 1'b1;
							end else begin
								acc_q <= acc_q | (64'd1 << rdata.loc);
							end
						end else begin
							acc_q <= acc_q | (64'd1 << rdata.loc);
						end
					end
					if (!rd_pend_q && idx_q == (IDX_W+1)'(RECORD_COUNT)) begin
						state_q <= S_TAIL;
						tail_q <= 3'd4;
						if (item_q.command == CMD_QUERY) begin
							q_push <= 1'b1;
							q_ev <= '{KIND_QUERY, 3'd0, 6'd0, MUT_NONE};
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_TAIL: begin
					unique case (tail_q)
						3'd0: begin
							// rescan the written table for the final mask
							rd_pend_q <= (idx_q < (IDX_W+1)'(RECORD_COUNT));
							if (idx_q < (IDX_W+1)'(RECORD_COUNT)) idx_q <= idx_q + 1'b1;
							if (rd_pend_q && rdata.tmo != 16'd0) begin
								acc_q <= acc_q | (64'd1 << rdata.loc);
							end
							if (!rd_pend_q && idx_q == (IDX_W+1)'(RECORD_COUNT)) begin
								tail_q <= 3'd1;
							end
						end
						3'd1: begin
							mut_q <= mut_code(item_q.presence_certain, prev_q, acc_q);
							tail_q <= 3'd2;
						end
						3'd2: begin
							if (mut_q != MUT_NONE) begin
								q_push <= 1'b1;
								q_ev <= '{KIND_MUTATION, 3'd0, 6'd0, mut_q};
								cnt_q <= cnt_q + 1'b1;
							end
							tail_q <= 3'd3;
						end
						3'd3: begin
							if (mut_q == MUT_FIRST || mut_q == MUT_LAST) begin
								q_push <= 1'b1;
								q_ev <= '{(mut_q == MUT_FIRST) ? KIND_FIRST_ENTER : KIND_LAST_EXIT,
								          3'd0, 6'd0, MUT_NONE};
								cnt_q <= cnt_q + 1'b1;
								tail_q <= 3'd5;
							end else begin
								tail_q <= 3'd6;
							end
						end
						3'd4: begin
							// tick or query
							if (item_q.command == CMD_TICK &&
							    mut_code(item_q.presence_certain, prev_q, acc_q) == MUT_LAST) begin
								q_push <= 1'b1;
								q_ev <= '{KIND_LAST_EXIT, 3'd0, 6'd0, MUT_NONE};
								cnt_q <= cnt_q + 1'b1;
								mut_q <= MUT_NONE;
								tail_q <= 3'd7;
							end else begin
								tail_q <= 3'd6;
							end
						end
						3'd5: begin
							q_push <= 1'b1;
							q_ev <= '{(mut_q == MUT_FIRST) ? KIND_PROF_ENTER : KIND_PROF_EXIT,
							          item_q.profile[2:0], item_q.location[5:0], MUT_NONE};
							cnt_q <= cnt_q + 1'b1;
							tail_q <= 3'd6;
						end
						3'd7: begin
							q_push <= 1'b1;
							q_ev <= '{KIND_PROF_EXIT, 3'd0, 6'd0, MUT_NONE};
							cnt_q <= cnt_q + 1'b1;
							tail_q <= 3'd6;
						end
						default: begin
							mask <= rep_mask;
							if (cnt_q != '0) begin
								q_drain <= 1'b1;
								state_q <= S_WAIT;
							end else begin
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_WAIT: begin
					if (q_empty && !q_drain) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/presence_table_timeout_tracker.sv -----
// presence table timeout tracker
// input channel: in_valid / in_stall carry one command (report, tick, query);
// a transfer happens when in_valid is high and in_stall is low
// output channel: out_valid / out_stall carry result events, last marks the
// final event of one command; commands with no effect give no events
// configuration: cfg_we writes cfg_data into register cfg_index; write only while idle, the block does not enforce this
// one command at a time: a report scans the 16-record memory, writes back
// and rescans for the occupancy mask; a due mesh countdown with a nonzero
// spread also waits for the jitter remainder; a tick is one read-modify-write
// pass and a query one read pass; when the command is processed, the events
// leave the event queue one at a time; in_stall drops once the final event
// is taken and the queue reports empty
// after reset all 16 records of the memory are cleared before in_stall drops
// a stalled receiver holds the event queue and the next command waits
module presence_table_timeout_tracker
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        q_empty;
	logic        q_push;
	event_t      q_ev;
	logic        q_clear;
	logic        q_drain;
	logic [63:0] mask;

	ptt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_empty(q_empty), .q_push(q_push), .q_ev(q_ev),
		.q_clear(q_clear), .q_drain(q_drain), .mask(mask)
	);

	ptt_evq u_evq (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_ev(q_ev), .clear(q_clear), .drain(q_drain),
		.mask(mask), .empty(q_empty), .valid(out_valid),
		.stall(out_stall), .out(out_data)
	);

endmodule

// ----- rtl/core/ptt_checker.sv -----
module ptt_checker
	import ptt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_busy_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while results pending");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind <= KIND_QUERY)
		else $error("bad result kind");

	a_mut_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_MUTATION |-> out_data.mutation == MUT_NONE)
		else $error("mutation code on other kind");

endmodule

bind presence_table_timeout_tracker ptt_checker u_ptt_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
